// ===== sv/sor_pkg.sv =====
package sor_pkg;

    // Sizes of the stores and the datapath.
    localparam int MAX_ORDER  = 16;
    localparam int IDX_W      = $clog2(MAX_ORDER);
    localparam int ORDER_W    = IDX_W + 1;
    localparam int VALUE_W    = 32;
    localparam int ACC_W      = 64;
    localparam int ITER_W     = 16;
    localparam int COEF_DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int COEF_AW    = 2 * IDX_W;
    localparam int DIV_CNT_W  = $clog2(ACC_W);
    localparam int RELAX_W    = VALUE_W + 7;

    // Operation codes of an input word.
    typedef enum logic [1:0] {
        OP_WRITE_MATRIX = 2'd0,
        OP_WRITE_RHS    = 2'd1,
        OP_SOLVE        = 2'd2
    } op_t;

    // Status codes of a solve.
    typedef enum logic [1:0] {
        ST_CONVERGED    = 2'd0,
        ST_NOT_DOMINANT = 2'd1,
        ST_ZERO_PIVOT   = 2'd2,
        ST_ITER_CAP     = 2'd3
    } status_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_ORDER     = 2'd0,
        CFG_TOLERANCE = 2'd1,
        CFG_MAX_ITER  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]                 operation;
        logic [IDX_W-1:0]           row;
        logic [IDX_W-1:0]           column;
        logic signed [VALUE_W-1:0]  value;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0]           index;
        logic signed [VALUE_W-1:0]  solution_value;
        logic [1:0]                 status;
        logic [ITER_W-1:0]          iterations;
        logic                       last;
    } result_t;

    // Divider request and response.
    typedef struct packed {
        logic               start;
        logic [ACC_W-1:0]   dividend;
        logic [VALUE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [ACC_W-1:0]   quotient;
    } div_rsp_t;

    // Saturating signed add.
    function automatic logic signed [ACC_W-1:0] add_sat(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1])
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        return s[ACC_W-1:0];
    endfunction

    // Saturating unsigned add.
    function automatic logic [ACC_W-1:0] uadd_sat(
        input logic [ACC_W-1:0] a,
        input logic [ACC_W-1:0] b
    );
        logic [ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
    endfunction

    // Magnitude of a signed accumulator value.
    function automatic logic [ACC_W-1:0] mag(input logic signed [ACC_W-1:0] v);
        return v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    endfunction

    // Signed quotient from magnitude and sign, saturated to a value.
    function automatic logic signed [VALUE_W-1:0] sat_quot(
        input logic [ACC_W-1:0] q,
        input logic             neg
    );
        logic big;
        big = |q[ACC_W-1:VALUE_W-1];
        if (neg)
            return big ? {1'b1, {(VALUE_W-1){1'b0}}} : VALUE_W'(-q[VALUE_W-1:0]);
        return big ? {1'b0, {(VALUE_W-1){1'b1}}} : q[VALUE_W-1:0];
    endfunction

    // Clamp a difference of two values back to value width.
    function automatic logic signed [VALUE_W-1:0] clamp_diff(
        input logic signed [VALUE_W:0] d
    );
        if (d[VALUE_W] != d[VALUE_W-1])
            return d[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
        return d[VALUE_W-1:0];
    endfunction

endpackage

// ===== sv/sor_divider.sv =====
module sor_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  sor_pkg::div_req_t req,
    output sor_pkg::div_rsp_t rsp
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [sor_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [sor_pkg::ACC_W-1:0]         dvd_reg, dvd_next;
    logic [sor_pkg::VALUE_W-1:0]       rem_reg, rem_next;
    logic [sor_pkg::VALUE_W-1:0]       dsr_reg, dsr_next;
    logic [sor_pkg::VALUE_W:0]         rem_sh;
    logic [sor_pkg::VALUE_W:0]         rem_sub;
    logic                              fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[sor_pkg::ACC_W-1]};
        fits    = rem_sh >= {1'b0, dsr_reg};
        rem_sub = fits ? rem_sh - {1'b0, dsr_reg} : rem_sh;
    end

    // Quotient bits enter the dividend register from the bottom.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[sor_pkg::ACC_W-2:0], fits};
            rem_next = rem_sub[sor_pkg::VALUE_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == {sor_pkg::DIV_CNT_W{1'b1}})
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

// ===== sv/sor_linear_solver.sv =====
// Load words (matrix or right-hand side entries) are taken one per cycle.
// A solve holds item_ready low until its last result word is loaded.
// Solve: a dominance check, the start measure, then per sweep the row updates
// and the change measure; a row with over-relaxation adds a divide by ten.
// The shared divider sets the row time. rst_n clears control state.
module sor_linear_solver (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  sor_pkg::item_t           item,
    output logic                     result_valid,
    input  logic                     result_ready,
    output sor_pkg::result_t         result,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [sor_pkg::ACC_W-1:0] cfg_data
);

    typedef enum logic [25:0] {
        S_IDLE      = 26'h0000001,
        S_DOM_DRD   = 26'h0000002,
        S_DOM_DLAT  = 26'h0000004,
        S_DOM_RD    = 26'h0000008,
        S_DOM_CMP   = 26'h0000010,
        S_INIT_RD   = 26'h0000020,
        S_INIT_SQ   = 26'h0000040,
        S_INIT_ADD  = 26'h0000080,
        S_CHECK     = 26'h0000100,
        S_ROW_RD    = 26'h0000200,
        S_ROW_PIV   = 26'h0000400,
        S_ROW_TRD   = 26'h0000800,
        S_ROW_TMUL  = 26'h0001000,
        S_ROW_TACC  = 26'h0002000,
        S_ROW_DIV   = 26'h0004000,
        S_ROW_DWAIT = 26'h0008000,
        S_ROW_RELAX = 26'h0010000,
        S_ROW_RWAIT = 26'h0020000,
        S_MROW      = 26'h0040000,
        S_MTRD      = 26'h0080000,
        S_MTMUL     = 26'h0100000,
        S_MTACC     = 26'h0200000,
        S_MSQ       = 26'h0400000,
        S_MADD      = 26'h0800000,
        S_MEND      = 26'h1000000,
        S_EMIT      = 26'h2000000
    } state_t;

    localparam int VW = sor_pkg::VALUE_W;
    localparam int AW = sor_pkg::ACC_W;
    localparam int IW = sor_pkg::IDX_W;

    state_t                        state_reg, state_next;
    logic [sor_pkg::ORDER_W-1:0]   order_reg, order_next;
    logic [AW-1:0]                 tol_reg, tol_next;
    logic [sor_pkg::ITER_W-1:0]    max_iter_reg, max_iter_next;
    logic [sor_pkg::ORDER_W-1:0]   n_reg, n_next;
    logic [IW-1:0]                 i_reg, i_next;
    logic [IW-1:0]                 j_reg, j_next;
    logic signed [AW-1:0]          acc_reg, acc_next;
    logic signed [VW-1:0]          piv_reg, piv_next;
    logic [VW-1:0]                 diag_reg, diag_next;
    logic [AW-1:0]                 residual_reg, residual_next;
    logic [AW-1:0]                 meas_reg, meas_next;
    logic                          over_reg, over_next;
    logic [sor_pkg::ITER_W-1:0]    sweep_reg, sweep_next;
    logic [1:0]                    status_reg, status_next;
    logic signed [VW-1:0]          q_reg, q_next;
    logic                          neg_reg, neg_next;
    logic [AW-1:0]                 mul_reg;
    sor_pkg::result_t              result_reg, result_next;
    logic                          result_valid_reg, result_valid_next;

    logic signed [VW-1:0]          cur_reg  [sor_pkg::MAX_ORDER];
    logic signed [VW-1:0]          prev_reg [sor_pkg::MAX_ORDER];
    logic signed [VW-1:0]          coef_mem [sor_pkg::COEF_DEPTH];
    logic signed [VW-1:0]          rhs_mem  [sor_pkg::MAX_ORDER];
    logic signed [VW-1:0]          coef_rdata, rhs_rdata;

    logic                          item_acc;
    logic                          coef_we, rhs_we;
    logic [sor_pkg::COEF_AW-1:0]   coef_raddr;
    logic                          vec_clear, vec_copy, cur_we;
    logic signed [VW-1:0]          cur_wdata;
    logic [IW-1:0]                 vec_addr;
    logic signed [VW-1:0]          cur_rd, prev_rd;
    logic                          i_last, j_last;
    logic signed [VW:0]            mul_a, mul_b;
    logic signed [VW-1:0]          diff_c;
    logic [VW-1:0]                 sq_in;
    logic [AW-1:0]                 acc_mag;
    logic signed [sor_pkg::RELAX_W-1:0] relax_q, relax_p, relax_diff;
    logic [sor_pkg::RELAX_W-1:0]   relax_mag;
    sor_pkg::div_req_t             div_req;
    sor_pkg::div_rsp_t             div_rsp;

    sor_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign item_ready   = (state_reg == S_IDLE);
    assign item_acc     = item_valid && item_ready;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign i_last = ({1'b0, i_reg} == n_reg - 1'b1);
    assign j_last = ({1'b0, j_reg} == n_reg - 1'b1);

    // Solution vector read port, shared by all sequencer steps.
    assign vec_addr = (state_reg == S_ROW_TMUL || state_reg == S_MTMUL) ? j_reg : i_reg;
    assign cur_rd   = cur_reg[vec_addr];
    assign prev_rd  = prev_reg[vec_addr];

    // Store writes from load words.
    assign coef_we = item_acc && (item.operation == sor_pkg::OP_WRITE_MATRIX);
    assign rhs_we  = item_acc && (item.operation == sor_pkg::OP_WRITE_RHS);
    assign coef_raddr = (state_reg == S_DOM_DRD || state_reg == S_ROW_RD) ?
                        {i_reg, i_reg} : {i_reg, j_reg};

    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[{item.row, item.column}] <= item.value;
        if (rhs_we)
            rhs_mem[item.row] <= item.value;
        coef_rdata <= coef_mem[coef_raddr];
        rhs_rdata  <= rhs_mem[i_reg];
    end

    // Operand helpers for the shared multiplier and the relaxation step.
    always_comb
    begin
        diff_c  = sor_pkg::clamp_diff({prev_rd[VW-1], prev_rd} - {cur_rd[VW-1], cur_rd});
        acc_mag = sor_pkg::mag(acc_reg);
        sq_in   = (|acc_mag[AW-1:VW+16]) ? {VW{1'b1}} : acc_mag[VW+15:16];
        relax_q = sor_pkg::RELAX_W'(q_reg);
        relax_p = sor_pkg::RELAX_W'(prev_rd);
        relax_diff = (relax_q <<< 4) + (relax_q <<< 1) + relax_q
                     - ((relax_p <<< 3) + relax_p);
        relax_mag = relax_diff[sor_pkg::RELAX_W-1] ?
                    sor_pkg::RELAX_W'(-relax_diff) : sor_pkg::RELAX_W'(relax_diff);
    end

    // Shared multiplier with a register on its output.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_INIT_SQ:
            begin
                mul_a = {rhs_rdata[VW-1], rhs_rdata};
                mul_b = {rhs_rdata[VW-1], rhs_rdata};
            end
            S_ROW_TMUL:
            begin
                mul_a = {coef_rdata[VW-1], coef_rdata};
                mul_b = {cur_rd[VW-1], cur_rd};
            end
            S_MTMUL:
            begin
                mul_a = {coef_rdata[VW-1], coef_rdata};
                mul_b = {diff_c[VW-1], diff_c};
            end
            S_MSQ:
            begin
                mul_a = {1'b0, sq_in};
                mul_b = {1'b0, sq_in};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= AW'(mul_a * mul_b);
    end

    // Divider requests: row quotient, then the relaxation divide by ten.
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = acc_mag;
        div_req.divisor  = piv_reg[VW-1] ? VW'(-piv_reg) : VW'(piv_reg);
        if (state_reg == S_ROW_DIV)
            div_req.start = (piv_reg != '0);
        else if (state_reg == S_ROW_RELAX)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = AW'(relax_mag);
            div_req.divisor  = VW'(10);
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next        = state_reg;
        order_next        = order_reg;
        tol_next          = tol_reg;
        max_iter_next     = max_iter_reg;
        n_next            = n_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        acc_next          = acc_reg;
        piv_next          = piv_reg;
        diag_next         = diag_reg;
        residual_next     = residual_reg;
        meas_next         = meas_reg;
        over_next         = over_reg;
        sweep_next        = sweep_reg;
        status_next       = status_reg;
        q_next            = q_reg;
        neg_next          = neg_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        vec_clear         = 1'b0;
        vec_copy          = 1'b0;
        cur_we            = 1'b0;
        cur_wdata         = sor_pkg::sat_quot(div_rsp.quotient, neg_reg);

        if (result_ready)
            result_valid_next = 1'b0;

        // Configuration writes.
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sor_pkg::CFG_ORDER:     order_next    = cfg_data[sor_pkg::ORDER_W-1:0];
                sor_pkg::CFG_TOLERANCE: tol_next      = cfg_data;
                sor_pkg::CFG_MAX_ITER:  max_iter_next = cfg_data[sor_pkg::ITER_W-1:0];
                default:                order_next    = order_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_acc && item.operation == sor_pkg::OP_SOLVE)
                begin
                    if (order_reg == '0)
                        n_next = sor_pkg::ORDER_W'(1);
                    else if (order_reg > sor_pkg::ORDER_W'(sor_pkg::MAX_ORDER))
                        n_next = sor_pkg::ORDER_W'(sor_pkg::MAX_ORDER);
                    else
                        n_next = order_reg;
                    vec_clear     = 1'b1;
                    over_next     = 1'b0;
                    sweep_next    = '0;
                    residual_next = '0;
                    i_next        = '0;
                    state_next    = S_DOM_DRD;
                end
            end
            S_DOM_DRD:
                state_next = S_DOM_DLAT;
            S_DOM_DLAT:
            begin
                diag_next  = coef_rdata[VW-1] ? VW'(-coef_rdata) : VW'(coef_rdata);
                j_next     = '0;
                state_next = S_DOM_RD;
            end
            S_DOM_RD:
                state_next = S_DOM_CMP;
            S_DOM_CMP:
            begin
                if (j_reg != i_reg &&
                    !(diag_reg > (coef_rdata[VW-1] ? VW'(-coef_rdata) : VW'(coef_rdata))))
                begin
                    status_next = sor_pkg::ST_NOT_DOMINANT;
                    i_next      = '0;
                    state_next  = S_EMIT;
                end
                else if (!j_last)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_DOM_RD;
                end
                else if (!i_last)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_DOM_DRD;
                end
                else
                begin
                    i_next     = '0;
                    state_next = S_INIT_RD;
                end
            end
            S_INIT_RD:
                state_next = S_INIT_SQ;
            S_INIT_SQ:
                state_next = S_INIT_ADD;
            S_INIT_ADD:
            begin
                residual_next = sor_pkg::uadd_sat(residual_reg, mul_reg);
                if (i_last)
                    state_next = S_CHECK;
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_INIT_RD;
                end
            end
            S_CHECK:
            begin
                i_next = '0;
                if (residual_reg > tol_reg)
                begin
                    if (sweep_reg >= max_iter_reg)
                    begin
                        status_next = sor_pkg::ST_ITER_CAP;
                        state_next  = S_EMIT;
                    end
                    else
                        state_next = S_ROW_RD;
                end
                else
                begin
                    status_next = sor_pkg::ST_CONVERGED;
                    state_next  = S_EMIT;
                end
            end
            S_ROW_RD:
                state_next = S_ROW_PIV;
            S_ROW_PIV:
            begin
                piv_next   = coef_rdata;
                acc_next   = AW'(rhs_rdata) <<< 16;
                j_next     = '0;
                state_next = S_ROW_TRD;
            end
            S_ROW_TRD:
                state_next = S_ROW_TMUL;
            S_ROW_TMUL:
                state_next = S_ROW_TACC;
            S_ROW_TACC:
            begin
                if (j_reg != i_reg)
                    acc_next = sor_pkg::add_sat(acc_reg, -$signed(mul_reg));
                if (j_last)
                    state_next = S_ROW_DIV;
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_ROW_TRD;
                end
            end
            S_ROW_DIV:
            begin
                if (piv_reg == '0)
                begin
                    status_next = sor_pkg::ST_ZERO_PIVOT;
                    i_next      = '0;
                    state_next  = S_EMIT;
                end
                else
                begin
                    neg_next   = acc_reg[AW-1] ^ piv_reg[VW-1];
                    state_next = S_ROW_DWAIT;
                end
            end
            S_ROW_DWAIT:
            begin
                if (div_rsp.done)
                begin
                    if (over_reg)
                    begin
                        q_next     = sor_pkg::sat_quot(div_rsp.quotient, neg_reg);
                        state_next = S_ROW_RELAX;
                    end
                    else
                    begin
                        cur_we = 1'b1;
                        if (i_last)
                        begin
                            meas_next  = '0;
                            i_next     = '0;
                            state_next = S_MROW;
                        end
                        else
                        begin
                            i_next     = i_reg + 1'b1;
                            state_next = S_ROW_RD;
                        end
                    end
                end
            end
            S_ROW_RELAX:
            begin
                neg_next   = relax_diff[sor_pkg::RELAX_W-1];
                state_next = S_ROW_RWAIT;
            end
            S_ROW_RWAIT:
            begin
                if (div_rsp.done)
                begin
                    cur_we = 1'b1;
                    if (i_last)
                    begin
                        meas_next  = '0;
                        i_next     = '0;
                        state_next = S_MROW;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_ROW_RD;
                    end
                end
            end
            S_MROW:
            begin
                acc_next   = '0;
                j_next     = '0;
                state_next = S_MTRD;
            end
            S_MTRD:
                state_next = S_MTMUL;
            S_MTMUL:
                state_next = S_MTACC;
            S_MTACC:
            begin
                acc_next = sor_pkg::add_sat(acc_reg, $signed(mul_reg));
                if (j_last)
                    state_next = S_MSQ;
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_MTRD;
                end
            end
            S_MSQ:
                state_next = S_MADD;
            S_MADD:
            begin
                meas_next = sor_pkg::uadd_sat(meas_reg, mul_reg);
                if (i_last)
                    state_next = S_MEND;
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_MROW;
                end
            end
            S_MEND:
            begin
                if (meas_reg < residual_reg)
                    over_next = 1'b1;
                residual_next = meas_reg;
                vec_copy      = 1'b1;
                sweep_next    = sweep_reg + 1'b1;
                state_next    = S_CHECK;
            end
            S_EMIT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.index          = i_reg;
                    result_next.solution_value = cur_rd;
                    result_next.status         = status_reg;
                    result_next.iterations     = sweep_reg;
                    result_next.last           = i_last;
                    result_valid_next          = 1'b1;
                    if (i_last)
                        state_next = S_IDLE;
                    else
                        i_next = i_reg + 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            order_reg        <= sor_pkg::ORDER_W'(sor_pkg::MAX_ORDER);
            tol_reg          <= AW'(1);
            max_iter_reg     <= {sor_pkg::ITER_W{1'b1}};
            n_reg            <= sor_pkg::ORDER_W'(sor_pkg::MAX_ORDER);
            i_reg            <= '0;
            j_reg            <= '0;
            residual_reg     <= '0;
            meas_reg         <= '0;
            over_reg         <= 1'b0;
            sweep_reg        <= '0;
            status_reg       <= sor_pkg::ST_CONVERGED;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            order_reg        <= order_next;
            tol_reg          <= tol_next;
            max_iter_reg     <= max_iter_next;
            n_reg            <= n_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            residual_reg     <= residual_next;
            meas_reg         <= meas_next;
            over_reg         <= over_next;
            sweep_reg        <= sweep_next;
            status_reg       <= status_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        piv_reg    <= piv_next;
        diag_reg   <= diag_next;
        q_reg      <= q_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

    // Solution vectors: cleared at a solve, row writes, copy after a sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < sor_pkg::MAX_ORDER; k++)
            begin
                cur_reg[k]  <= '0;
                prev_reg[k] <= '0;
            end
        end
        else if (vec_clear)
        begin
            for (int k = 0; k < sor_pkg::MAX_ORDER; k++)
            begin
                cur_reg[k]  <= '0;
                prev_reg[k] <= '0;
            end
        end
        else if (vec_copy)
        begin
            for (int k = 0; k < sor_pkg::MAX_ORDER; k++)
                prev_reg[k] <= cur_reg[k];
        end
        else if (cur_we)
            cur_reg[i_reg] <= cur_wdata;
    end

endmodule

// ===== sv/sor_checker.sv =====
module sor_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_ready,
    input logic             result_valid,
    input logic             result_ready,
    input sor_pkg::result_t result
);

    // A waiting result word holds until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // Words of one solve follow each other with rising index.
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result.last |=>
            result_valid && (result.index == 4'($past(result.index) + 4'd1)))
        else $error("result index did not advance");

    // Status and sweep count are the same on every word of a solve.
    a_status_same: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result.last |=>
            (result.status == $past(result.status)) &&
            (result.iterations == $past(result.iterations)))
        else $error("status changed within a solve");

    // No new word is taken while a solve is still giving results.
    a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> !item_ready)
        else $error("input taken during result output");

endmodule

bind sor_linear_solver sor_checker u_sor_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import sor_pkg::*;

    // Operation code that the block ignores.
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam longint VAL_MAX = 64'sd2147483647;
    localparam longint VAL_MIN = -64'sd2147483648;
    localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint I64_MIN = 64'sh8000_0000_0000_0000;
    localparam longint ONE_Q16 = 64'sd65536;

    // Kinds of linear system that the loader can build.
    typedef enum int {
        SYS_DOMINANT,
        SYS_IDENTITY,
        SYS_WILD,
        SYS_FLAT
    } system_kind_t;

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_ready;
    item_t               item;
    logic                result_valid;
    logic                result_ready;
    result_t             result;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [ACC_W-1:0]    cfg_data;

    // Shadow copy of the stores and registers of the solver.
    longint              coef_mem [COEF_DEPTH];
    longint              rhs_mem [MAX_ORDER];
    logic [ORDER_W-1:0]  order_reg;
    logic [ACC_W-1:0]    tolerance_reg;
    logic [ITER_W-1:0]   sweep_cap_reg;

    result_t             solution_q [$];
    int                  fail_count;
    int                  words_sent;
    bit                  quiet;
    bit                  hold_off_req;

    sor_linear_solver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // Saturating fixed-point arithmetic on 64-bit values: Q16.16 operands, Q32.32 products.
    function automatic logic [63:0] mag64(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint signed_from_mag(input logic [63:0] m, input bit neg);
        if (neg)
            return (m >= 64'h8000_0000_0000_0000) ? I64_MIN : -longint'(m);
        return (m > 64'(I64_MAX)) ? I64_MAX : longint'(m);
    endfunction

    function automatic longint add_s64(input longint a, input longint b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(I64_MAX))
            return I64_MAX;
        if (s < 65'(I64_MIN))
            return I64_MIN;
        return longint'(s);
    endfunction

    function automatic longint mul_s64(input longint a, input longint b);
        logic [127:0] p;
        p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
        if (p[127:64] != 0)
            p[63:0] = '1;
        return signed_from_mag(p[63:0], (a < 0) != (b < 0));
    endfunction

    function automatic longint clamp_q16(input longint v);
        if (v > VAL_MAX)
            return VAL_MAX;
        if (v < VAL_MIN)
            return VAL_MIN;
        return v;
    endfunction

    function automatic logic [63:0] uadd64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] square_q(input longint v);
        logic [63:0] m;
        m = mag64(v);
        if (m > 64'hFFFF_FFFF)
            m = 64'hFFFF_FFFF;
        return m * m;
    endfunction

    function automatic bit is_dominant(input int n);
        logic [63:0] d;
        for (int i = 0; i < n; i++)
        begin
            d = mag64(coef_mem[i * MAX_ORDER + i]);
            for (int j = 0; j < n; j++)
                if (j != i && !(d > mag64(coef_mem[i * MAX_ORDER + j])))
                    return 0;
        end
        return 1;
    endfunction

    // Runs the relaxation sweeps on the shadow stores and queues the
    // solution words that the solve must produce.
    task automatic predict_solution();
        int          n;
        int          sweeps;
        longint      x [MAX_ORDER];
        longint      x_prev [MAX_ORDER];
        longint      acc;
        longint      q;
        longint      piv;
        logic [63:0] measure;
        logic [63:0] m;
        bit          relax;
        bit          stop;
        status_t     st;
        result_t     r;
        n = (order_reg == 0) ? 1 : ((order_reg > MAX_ORDER) ? MAX_ORDER : int'(order_reg));
        for (int i = 0; i < MAX_ORDER; i++)
        begin
            x[i] = 0;
            x_prev[i] = 0;
        end
        relax = 0;
        sweeps = 0;
        measure = 0;
        stop = 0;
        st = ST_CONVERGED;
        if (!is_dominant(n))
            st = ST_NOT_DOMINANT;
        else
        begin
            for (int i = 0; i < n; i++)
                measure = uadd64(measure, square_q(rhs_mem[i]));
            while (!stop && measure > tolerance_reg)
            begin
                if (sweeps >= sweep_cap_reg)
                begin
                    st = ST_ITER_CAP;
                    stop = 1;
                end
                else
                begin
                    // One in-place sweep over the rows.
                    for (int i = 0; i < n && !stop; i++)
                    begin
                        acc = mul_s64(rhs_mem[i], ONE_Q16);
                        for (int j = 0; j < n; j++)
                            if (j != i)
                                acc = add_s64(acc, -mul_s64(coef_mem[i * MAX_ORDER + j], x[j]));
                        piv = coef_mem[i * MAX_ORDER + i];
                        if (piv == 0)
                        begin
                            st = ST_ZERO_PIVOT;
                            stop = 1;
                        end
                        else
                        begin
                            q = clamp_q16(signed_from_mag(mag64(acc) / mag64(piv),
                                                          (acc < 0) != (piv < 0)));
                            if (relax)
                                q = clamp_q16((19 * q - 9 * x_prev[i]) / 10);
                            x[i] = q;
                        end
                    end
                    // Measure of the change made by this sweep.
                    if (!stop)
                    begin
                        m = 0;
                        for (int i = 0; i < n; i++)
                        begin
                            acc = 0;
                            for (int j = 0; j < n; j++)
                                acc = add_s64(acc, mul_s64(coef_mem[i * MAX_ORDER + j],
                                                           clamp_q16(x_prev[j] - x[j])));
                            m = uadd64(m, square_q(signed_from_mag(mag64(acc) >> 16,
                                                                   acc < 0)));
                        end
                        if (m < measure)
                            relax = 1;
                        measure = m;
                        for (int i = 0; i < MAX_ORDER; i++)
                            x_prev[i] = x[i];
                        sweeps = (sweeps + 1) & 16'hFFFF;
                    end
                end
            end
        end
        for (int i = 0; i < n; i++)
        begin
            r.index = IDX_W'(i);
            r.solution_value = x[i][VALUE_W-1:0];
            r.status = st;
            r.iterations = ITER_W'(sweeps);
            r.last = (i == n - 1);
            solution_q.push_back(r);
        end
    endtask

    function automatic item_t make_word(input logic [1:0] op, input int row, input int col,
                                        input logic [31:0] val);
        item_t w;
        w.operation = op;
        w.row = IDX_W'(row);
        w.column = IDX_W'(col);
        w.value = val;
        return w;
    endfunction

    function automatic logic [31:0] rand_signed(input int unsigned limit);
        logic [31:0] v;
        v = $urandom_range(0, limit);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // Sends one word and applies it to the shadow model once it is taken.
    task automatic send_word(input item_t w);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= w;
        do @(posedge clk); while (!item_ready);
        words_sent++;
        case (w.operation)
            OP_WRITE_MATRIX: coef_mem[w.row * MAX_ORDER + w.column] = longint'(w.value);
            OP_WRITE_RHS:    rhs_mem[w.row] = longint'(w.value);
            OP_SOLVE:        predict_solution();
            default:         ;
        endcase
    endtask

    // Drops valid, waits for every outstanding solution word and lets the
    // last load words settle.
    task automatic drain();
        item_valid <= 1'b0;
        while (solution_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [ACC_W-1:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ORDER:     order_reg = data[ORDER_W-1:0];
            CFG_TOLERANCE: tolerance_reg = data;
            CFG_MAX_ITER:  sweep_cap_reg = data[ITER_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic setup(input int ord, input logic [63:0] tol, input int cap);
        write_reg(CFG_ORDER, 64'(ord));
        write_reg(CFG_TOLERANCE, tol);
        write_reg(CFG_MAX_ITER, 64'(cap));
    endtask

    // Writes a whole system of order n, with the odd ignored or stray word
    // mixed in, and then starts a solve.
    task automatic load_and_solve(input int n, input system_kind_t kind);
        logic [31:0] v;
        logic [31:0] flat;
        flat = $urandom_range(1, 32'h0004_0000);
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < n; j++)
            begin
                case (kind)
                    SYS_DOMINANT:
                        v = (i == j) ? rand_signed(n * 32'h0004_0000 + $urandom_range(1, 32'h0010_0000))
                                     : rand_signed(32'h0004_0000);
                    SYS_IDENTITY: v = (i == j) ? 32'h0001_0000 : 32'h0;
                    SYS_WILD:     v = $urandom;
                    default:      v = $urandom_range(0, 1) ? flat : -flat;
                endcase
                send_word(make_word(OP_WRITE_MATRIX, i, j, v));
                if (!quiet && $urandom_range(0, 9) == 0)
                    send_word(make_word(OP_RESERVED, $urandom, $urandom, $urandom));
            end
            v = (kind == SYS_WILD) ? $urandom : rand_signed(32'h0040_0000);
            send_word(make_word(OP_WRITE_RHS, i, 0, v));
        end
        // Entries beyond the order in use are stored but play no part.
        if (n < MAX_ORDER && $urandom_range(0, 2) == 0)
            send_word(make_word(OP_WRITE_MATRIX, $urandom_range(n, MAX_ORDER - 1),
                                $urandom_range(0, MAX_ORDER - 1), $urandom));
        send_word(make_word(OP_SOLVE, $urandom, $urandom, $urandom));
    endtask

    // One unknown: value extremes, saturation, a zero pivot and a zero
    // right-hand side.
    task automatic test_single_unknown();
        setup(1, 64'd1, 8);
        send_word(make_word(OP_WRITE_MATRIX, 0, 0, 32'h8000_0000));
        send_word(make_word(OP_WRITE_RHS, 0, 0, 32'h7FFF_FFFF));
        send_word(make_word(OP_SOLVE, 0, 0, 0));
        send_word(make_word(OP_WRITE_MATRIX, 0, 0, 32'h0000_0001));
        send_word(make_word(OP_SOLVE, 15, 15, 32'hFFFF_FFFF));
        send_word(make_word(OP_WRITE_MATRIX, 0, 0, 32'h7FFF_FFFF));
        send_word(make_word(OP_WRITE_RHS, 0, 0, 32'h8000_0000));
        send_word(make_word(OP_SOLVE, 0, 0, 0));
        send_word(make_word(OP_WRITE_MATRIX, 0, 0, 32'h0));
        send_word(make_word(OP_WRITE_RHS, 0, 0, 32'h0005_0000));
        send_word(make_word(OP_SOLVE, 0, 0, 0));
        send_word(make_word(OP_RESERVED, 15, 15, 32'hFFFF_FFFF));
        send_word(make_word(OP_WRITE_RHS, 0, 0, 32'h0));
        send_word(make_word(OP_SOLVE, 0, 0, 0));
        // An order of zero acts as one.
        write_reg(CFG_ORDER, 64'd0);
        send_word(make_word(OP_WRITE_MATRIX, 0, 0, 32'hFFFF_0000));
        send_word(make_word(OP_WRITE_RHS, 0, 0, 32'h0001_0000));
        send_word(make_word(OP_SOLVE, 0, 0, 0));
    endtask

    // Rows whose diagonal does not strictly exceed the other entries.
    task automatic test_not_dominant();
        setup(3, 64'd1, 8);
        load_and_solve(3, SYS_FLAT);
        write_reg(CFG_ORDER, 64'd2);
        send_word(make_word(OP_WRITE_MATRIX, 0, 0, 32'h0002_0000));
        send_word(make_word(OP_WRITE_MATRIX, 0, 1, 32'h0001_0000));
        send_word(make_word(OP_WRITE_MATRIX, 1, 0, 32'hFFFD_0000));
        send_word(make_word(OP_WRITE_MATRIX, 1, 1, 32'h0003_0000));
        send_word(make_word(OP_WRITE_RHS, 0, 0, 32'h0001_0000));
        send_word(make_word(OP_WRITE_RHS, 1, 0, 32'h0001_0000));
        send_word(make_word(OP_SOLVE, 0, 0, 0));
    endtask

    // Tolerance and sweep cap at their extremes.
    task automatic test_register_extremes();
        setup(2, 64'hFFFF_FFFF_FFFF_FFFF, 65535);
        load_and_solve(2, SYS_IDENTITY);
        write_reg(CFG_TOLERANCE, 64'd0);
        load_and_solve(2, SYS_IDENTITY);
        write_reg(CFG_MAX_ITER, 64'd0);
        load_and_solve(2, SYS_DOMINANT);
        write_reg(CFG_MAX_ITER, 64'd1);
        load_and_solve(2, SYS_DOMINANT);
    endtask

    // Order above the store size acts as the full size.
    task automatic test_full_order();
        setup(31, 64'd1, 2);
        load_and_solve(MAX_ORDER, SYS_DOMINANT);
    endtask

    // A long receiver hold-off while further words are offered.
    task automatic test_back_pressure();
        setup(4, 64'd1, 3);
        quiet = 1;
        hold_off_req = 1;
        load_and_solve(4, SYS_DOMINANT);
        load_and_solve(4, SYS_DOMINANT);
        quiet = 0;
    endtask

    task automatic test_random_solves(input int target);
        int n;
        int pick;
        system_kind_t kind;
        while (words_sent < target)
        begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
            pick = $urandom_range(0, 3);
            setup(n, (pick == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 1 << 20)),
                  $urandom_range(1, 12));
            pick = $urandom_range(0, 9);
            kind = (pick < 7) ? SYS_DOMINANT : (pick == 7) ? SYS_IDENTITY :
                   (pick == 8) ? SYS_WILD : SYS_FLAT;
            quiet = ($urandom_range(0, 3) == 0);
            load_and_solve(n, kind);
        end
        quiet = 0;
    endtask

    // Receiver: draws a stall per word and checks each word taken.
    initial
    begin
        result_t expected;
        int      stall;
        result_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                result_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_off_req = 0;
            end
            stall = quiet ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            if (solution_q.size() == 0)
            begin
                $error("solution word with none expected: index %0d", result.index);
                fail_count++;
            end
            else
            begin
                expected = solution_q.pop_front();
                if (result.index !== expected.index)
                begin
                    $error("index expected %0d got %0d", expected.index, result.index);
                    fail_count++;
                end
                if (result.solution_value !== expected.solution_value)
                begin
                    $error("solution_value expected %0d got %0d",
                           expected.solution_value, result.solution_value);
                    fail_count++;
                end
                if (result.status !== expected.status)
                begin
                    $error("status expected %0d got %0d", expected.status, result.status);
                    fail_count++;
                end
                if (result.iterations !== expected.iterations)
                begin
                    $error("iterations expected %0d got %0d",
                           expected.iterations, result.iterations);
                    fail_count++;
                end
                if (result.last !== expected.last)
                begin
                    $error("last expected %0d got %0d", expected.last, result.last);
                    fail_count++;
                end
            end
        end
    end

    // Overall time limit.
    initial
    begin
        #100000000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        fail_count = 0;
        words_sent = 0;
        quiet = 0;
        hold_off_req = 0;
        order_reg = 16;
        tolerance_reg = 1;
        sweep_cap_reg = 16'hFFFF;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_unknown();
        test_not_dominant();
        test_register_extremes();
        test_full_order();
        test_back_pressure();
        test_random_solves(words_sent + 320);

        drain();
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
